/* sv/biquad_filter_noise_shaped_macros.svh */
// Assertion helpers shared by the checker files.
// Each property samples on the rising edge of clk and is masked while rst_n is low.
`ifndef BIQUAD_FILTER_NOISE_SHAPED_MACROS_SVH
`define BIQUAD_FILTER_NOISE_SHAPED_MACROS_SVH

// Same-cycle implication: cons (which may start with a ## delay) follows ante.
`define BQNS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define BQNS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

/* sv/bqns_pkg.sv */
`default_nettype none

package bqns_pkg;

    localparam int TAPS        = 5;
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 32;
    localparam int PROD_W      = COEF_W + SAMPLE_W;
    localparam int TERM_SHIFT  = 16;
    localparam int ACC_W       = 32;
    localparam int RESIDUE_W   = 14;
    localparam int CFG_INDEX_W = 3;

    localparam logic [RESIDUE_W-1:0] RESIDUE_MASK = 14'h3FFF;

    // Register map of the configuration channel
    localparam logic [CFG_INDEX_W-1:0] CFG_COEF_B0  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COEF_B1  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COEF_B2  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COEF_A1N = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_COEF_A2N = 3'd4;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    typedef struct packed {
        coef_t b0;
        coef_t b1;
        coef_t b2;
        coef_t a1_negated;
        coef_t a2_negated;
    } coef_set_t;

    typedef struct packed {
        sample_t                input_delay_one;
        sample_t                input_delay_two;
        sample_t                output_delay_one;
        sample_t                output_delay_two;
        logic [RESIDUE_W-1:0]   shaping_residue;
    } filter_state_t;

endpackage

`default_nettype wire

/* sv/biquad_filter_noise_shaped.sv */
// Single biquad stage, direct form 1, with first-order noise shaping of the
// output rounding.
// Channels: samples enter on s_* and leave on m_*, one filtered sample per
// request taken, in order. Coefficients (Q30, feedback held negated) are
// written on cfg_*: index 0 b0, 1 b1, 2 b2, 3 -a1, 4 -a2; other indexes drop.
// cfg_ready is always high; write coefficients only while no sample is in
// flight.
// A taken sample is held in the input register; its result is computed from
// it and registered into the output register, which drives m_tdata.
// Throughput: one sample per cycle while m_tready is high. The limit is the
// feedback path: the new output feeds the next sample's multiply, so the
// five 32x16 products, adder chain and saturator sit in that loop unregistered.
// Reset: clears coefficients, delay lines, residue and both valid flags.
// Stall: while m_tready is low the result holds; one more sample can still
// wait in the input register, after which s_tready drops.
`default_nettype none

module biquad_filter_noise_shaped
    import bqns_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [15:0]            s_tdata,   // [15:0] sample_in

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [15:0]                 m_tdata,   // [15:0] sample_out

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [COEF_W-1:0]      cfg_data
);

    coef_set_t              coefs;
    filter_state_t          state_reg;
    filter_state_t          state_next;

    logic                   in_valid_reg;
    logic                   in_valid_next;
    sample_t                in_sample_reg;
    sample_t                in_sample_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    sample_t                out_sample_reg;
    sample_t                out_sample_next;

    sample_t                result;
    logic [RESIDUE_W-1:0]   residue;
    logic                   advance;
    logic                   take_in;

    assign cfg_ready = 1'b1;

    bqns_coef_regs u_coef_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .coefs    (coefs)
    );

    bqns_datapath u_datapath (
        .coefs    (coefs),
        .state    (state_reg),
        .sample   (in_sample_reg),
        .result   (result),
        .residue  (residue)
    );

    // Advance the held sample when the result slot is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take_in  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next   = in_valid_reg;
        in_sample_next  = in_sample_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        state_next      = state_reg;

        if (advance)
        begin
            in_valid_next   = 1'b0;
            out_valid_next  = 1'b1;
            out_sample_next = result;
            // Shift the delay lines and keep the dropped low bits
            state_next.input_delay_two  = state_reg.input_delay_one;
            state_next.input_delay_one  = in_sample_reg;
            state_next.output_delay_two = state_reg.output_delay_one;
            state_next.output_delay_one = result;
            state_next.shaping_residue  = residue;
        end
        else if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (take_in)
        begin
            in_valid_next  = 1'b1;
            in_sample_next = s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload holds need no reset
    always_ff @(posedge clk)
    begin
        in_sample_reg  <= in_sample_next;
        out_sample_reg <= out_sample_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;

endmodule

`default_nettype wire

/* sv/bqns_coef_regs.sv */
`default_nettype none

module bqns_coef_regs
    import bqns_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [COEF_W-1:0]      wr_data,
    output coef_set_t                   coefs
);

    coef_set_t coefs_reg;
    coef_set_t coefs_next;

    always_comb
    begin
        coefs_next = coefs_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_COEF_B0:  coefs_next.b0         = wr_data;
                CFG_COEF_B1:  coefs_next.b1         = wr_data;
                CFG_COEF_B2:  coefs_next.b2         = wr_data;
                CFG_COEF_A1N: coefs_next.a1_negated = wr_data;
                CFG_COEF_A2N: coefs_next.a2_negated = wr_data;
                default:      coefs_next            = coefs_reg; // drop unmapped writes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg <= '0;
        end
        else
        begin
            coefs_reg <= coefs_next;
        end
    end

    assign coefs = coefs_reg;

endmodule

`default_nettype wire

/* sv/bqns_datapath.sv */
`default_nettype none

module bqns_datapath
    import bqns_pkg::*;
(
    input  coef_set_t               coefs,
    input  filter_state_t           state,
    input  sample_t                 sample,
    output sample_t                 result,
    output logic [RESIDUE_W-1:0]    residue
);

    localparam logic signed [ACC_W-RESIDUE_W-1:0] SAT_HI = 18'sd32767;
    localparam logic signed [ACC_W-RESIDUE_W-1:0] SAT_LO = -18'sd32768;

    coef_t                              coef_op [TAPS];
    sample_t                            smp_op  [TAPS];
    logic signed [PROD_W-1:0]           prod    [TAPS];
    logic [ACC_W-1:0]                   acc;
    logic signed [ACC_W-RESIDUE_W-1:0]  shifted;

    always_comb
    begin
        coef_op[0] = coefs.b0;
        coef_op[1] = coefs.b1;
        coef_op[2] = coefs.b2;
        coef_op[3] = coefs.a1_negated;
        coef_op[4] = coefs.a2_negated;
        smp_op[0]  = sample;
        smp_op[1]  = state.input_delay_one;
        smp_op[2]  = state.input_delay_two;
        smp_op[3]  = state.output_delay_one;
        smp_op[4]  = state.output_delay_two;
    end

    // Start from the residue, add each product floored by 2^16, wrap at 32 bits
    always_comb
    begin
        acc = {{(ACC_W-RESIDUE_W){1'b0}}, state.shaping_residue};
        for (int i = 0; i < TAPS; i++)
        begin
            prod[i] = PROD_W'(coef_op[i]) * PROD_W'(smp_op[i]);
            acc     = acc + prod[i][TERM_SHIFT+ACC_W-1:TERM_SHIFT];
        end
    end

    always_comb
    begin
        shifted = acc[ACC_W-1:RESIDUE_W];
        if (shifted > SAT_HI)
            result = SAT_HI[SAMPLE_W-1:0];
        else if (shifted < SAT_LO)
            result = SAT_LO[SAMPLE_W-1:0];
        else
            result = shifted[SAMPLE_W-1:0];
    end

    assign residue = acc[RESIDUE_W-1:0] & RESIDUE_MASK;

endmodule

`default_nettype wire

/* sv/bqns_checker.sv */
`default_nettype none
`include "biquad_filter_noise_shaped_macros.svh"

module bqns_checker
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [15:0]            m_tdata
);

    `BQNS_ASSERT_IMPL(a_accept_gives_result, s_tvalid && s_tready, ##2 m_tvalid, "no result two edges after a request was taken")
    `BQNS_ASSERT_IMPL(a_empty_output_ready, !m_tvalid, s_tready, "input stalled with an empty output stage")
    `BQNS_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    `BQNS_ASSERT_IMPL(a_reset_clears_output, $rose(rst_n), !m_tvalid, "result valid straight out of reset")

endmodule

bind biquad_filter_noise_shaped bqns_checker u_bqns_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

`default_nettype wire
